[hw/rtl/rcelp_pkg.sv]
package rcelp_pkg;

    localparam int unsigned EXP_W   = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned NDIG_W  = 4;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CHAR_W  = 8;

    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_EXPONENT = 2'd1;

    localparam logic [6:0] PAIR_RADIX  = 7'd10;
    localparam logic [6:0] PAIR_LOWER  = 7'd26;
    localparam logic [6:0] PAIR_UPPER  = 7'd52;
    localparam logic [7:0] LOWER_BASE  = 8'd97;
    localparam logic [7:0] UPPER_BASE  = 8'd39;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;

    // reciprocal of ten for a 32-bit dividend, shift by 35
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    function automatic logic [63:0] pow10(input int unsigned k);
        logic [63:0] p;
        p = 64'd1;
        for (int unsigned i = 0; i < 10; i++) begin
            if (i < k) p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

[hw/rtl/rcelp_fifo.sv]
module rcelp_fifo #(
    parameter int unsigned WIDTH = 45
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wr <= ~r_wr;
            if (i_pop && o_valid) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0) - 2'((i_pop && o_valid) ? 1 : 0);
        end
    end
endmodule

[hw/rtl/rcelp_front.sv]
module rcelp_front #(
    parameter int unsigned MOD_WIDTH  = 32,
    parameter int unsigned MAX_DIGITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [MOD_WIDTH-1:0]       i_modulus,
    input  logic [rcelp_pkg::EXP_W-1:0] i_exponent,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_plain_char,
    input  logic                       i_last_char,
    output logic                       o_push,
    output logic [MAX_DIGITS*rcelp_pkg::DIGIT_W+rcelp_pkg::NDIG_W:0] o_rec,
    input  logic                       i_full
);
    import rcelp_pkg::*;

    localparam int unsigned CW = $clog2(MOD_WIDTH);
    localparam int unsigned KW = $clog2(MAX_DIGITS);
    localparam int unsigned EW = $clog2(EXP_W);

    typedef enum logic [2:0] {S_IDLE, S_MM, S_DIG, S_PUSH} t_state;
    typedef enum logic [1:0] {OP_RED, OP_SQR, OP_MUL} t_op;

    t_state                r_state;
    t_op                   r_op;
    logic [MOD_WIDTH-1:0]  r_n;
    logic [EXP_W-1:0]      r_e;
    logic [EW-1:0]         r_ei;
    logic [MOD_WIDTH-1:0]  r_base;
    logic [MOD_WIDTH-1:0]  r_res;
    logic [MOD_WIDTH-1:0]  r_acc;
    logic [MOD_WIDTH-1:0]  r_x;
    logic [MOD_WIDTH-1:0]  r_y;
    logic [CW-1:0]         r_cnt;
    logic [VAL_W-1:0]      r_val;
    logic [KW-1:0]         r_k;
    logic [NDIG_W-1:0]     r_ndig;
    logic                  r_last;
    logic [DIGIT_W-1:0]    r_dig [MAX_DIGITS];

    logic                  w_accept;
    logic [NDIG_W-1:0]     w_ndig;
    logic [MOD_WIDTH+1:0]  w_t;
    logic [MOD_WIDTH+1:0]  w_n1;
    logic [MOD_WIDTH+1:0]  w_n2;
    logic [MOD_WIDTH-1:0]  w_mm;
    logic [63:0]           w_prod;
    logic [VAL_W-1:0]      w_q;
    logic [VAL_W-1:0]      w_rem;
    logic [MAX_DIGITS*DIGIT_W-1:0] w_digits;

    assign o_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept = i_valid && !o_stall;

    // digit count of the modulus, saturating
    always_comb begin
        w_ndig = '0;
        if (i_modulus != '0) begin
            w_ndig = NDIG_W'(1);
            for (int unsigned k = 1; k < MAX_DIGITS; k++) begin
                if (64'(i_modulus) >= pow10(k)) w_ndig = w_ndig + NDIG_W'(1);
            end
        end
    end

    // one step of interleaved modular multiply, acc stays below n
    always_comb begin
        w_n1 = (MOD_WIDTH+2)'(r_n);
        w_n2 = {1'b0, r_n, 1'b0};
        w_t  = {1'b0, r_acc, 1'b0} + (r_x[MOD_WIDTH-1] ? (MOD_WIDTH+2)'(r_y) : '0);
        if (w_t >= w_n2) begin
            w_t = w_t - w_n2;
        end else if (w_t >= w_n1) begin
            w_t = w_t - w_n1;
        end
        w_mm = w_t[MOD_WIDTH-1:0];
    end

    always_comb begin
        w_prod = 64'(r_val) * 64'(RECIP_TEN);
        w_q    = VAL_W'(w_prod[63:35]);
        w_rem  = r_val - ((w_q << 3) + (w_q << 1));
    end

    always_comb begin
        for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
            w_digits[i*DIGIT_W +: DIGIT_W] = r_dig[i];
        end
    end

    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_rec  = {r_last, r_ndig, w_digits};

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIG) begin
            r_dig[r_k] <= w_rem[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_RED;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n    <= i_modulus;
                        r_e    <= i_exponent;
                        r_last <= i_last_char;
                        r_ndig <= w_ndig;
                        r_ei   <= EW'(EXP_W - 1);
                        r_res  <= MOD_WIDTH'(1);
                        r_k    <= '0;
                        if (i_modulus == '0) begin
                            r_state <= S_PUSH;
                        end else if (i_exponent == '0) begin
                            r_val   <= VAL_W'(1);
                            r_state <= S_DIG;
                        end else begin
                            // base = plain mod n
                            r_x     <= MOD_WIDTH'(i_plain_char);
                            r_y     <= MOD_WIDTH'(1);
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_op    <= OP_RED;
                            r_state <= S_MM;
                        end
                    end
                end
                S_MM: begin
                    r_acc <= w_mm;
                    r_x   <= r_x << 1;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(MOD_WIDTH - 1)) begin
                        r_acc <= '0;
                        r_cnt <= '0;
                        case (r_op)
                            OP_RED: begin
                                r_base <= w_mm;
                                r_x    <= r_res;
                                r_y    <= r_res;
                                r_op   <= OP_SQR;
                            end
                            OP_SQR: begin
                                r_res <= w_mm;
                                if (r_e[r_ei]) begin
                                    r_x  <= w_mm;
                                    r_y  <= r_base;
                                    r_op <= OP_MUL;
                                end else if (r_ei == '0) begin
                                    r_val   <= VAL_W'(w_mm);
                                    r_state <= S_DIG;
                                end else begin
                                    r_ei <= r_ei - EW'(1);
                                    r_x  <= w_mm;
                                    r_y  <= w_mm;
                                end
                            end
                            default: begin
                                r_res <= w_mm;
                                if (r_ei == '0) begin
                                    r_val   <= VAL_W'(w_mm);
                                    r_state <= S_DIG;
                                end else begin
                                    r_ei <= r_ei - EW'(1);
                                    r_x  <= w_mm;
                                    r_y  <= w_mm;
                                    r_op <= OP_SQR;
                                end
                            end
                        endcase
                    end
                end
                S_DIG: begin
                    r_val <= w_q;
                    r_k   <= r_k + KW'(1);
                    if (r_k == KW'(r_ndig - NDIG_W'(1))) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_acc_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MM) |-> (r_acc < r_n))
        else $error("modmul accumulator not reduced");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept) |=> (r_state != S_IDLE))
        else $error("front did not leave idle after accept");
    a_ndig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> (r_ndig != '0 && r_ndig <= NDIG_W'(MAX_DIGITS)))
        else $error("digit count out of range");
endmodule

[hw/rtl/rcelp_back.sv]
module rcelp_back #(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rec_valid,
    input  logic [MAX_DIGITS*rcelp_pkg::DIGIT_W+rcelp_pkg::NDIG_W:0] i_rec,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_cipher_char,
    output logic       o_last_out
);
    import rcelp_pkg::*;

    localparam int unsigned DW = MAX_DIGITS * DIGIT_W;

    logic                r_loaded;
    logic [NDIG_W-1:0]   r_left;
    logic                r_pend_valid;
    logic [DIGIT_W-1:0]  r_pend_digit;
    logic                r_extra_valid;
    logic [CHAR_W-1:0]   r_extra_char;
    logic                r_hold_valid;
    logic [CHAR_W-1:0]   r_hold_char;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    logic                w_last;
    logic [NDIG_W-1:0]   w_ndig;
    logic [DW-1:0]       w_digits;
    logic [NDIG_W-1:0]   w_idx;
    logic [DIGIT_W-1:0]  w_d;
    logic [6:0]          w_pair;
    logic                w_out_free;
    logic                w_gen;
    logic [CHAR_W-1:0]   w_char;
    logic                w_flush;
    logic                w_step;

    assign {w_last, w_ndig, w_digits} = i_rec;
    assign w_idx      = r_left - NDIG_W'(1);
    assign w_d        = w_digits[w_idx*DIGIT_W +: DIGIT_W];
    assign w_pair     = 7'(r_pend_digit) * PAIR_RADIX + 7'(w_d);
    assign w_out_free = !r_out_valid || !i_stall;

    // what the sequencer does this cycle, and the char it makes
    always_comb begin
        w_gen   = 1'b0;
        w_flush = 1'b0;
        w_char  = '0;
        if (i_rec_valid && r_loaded) begin
            if (r_extra_valid) begin
                w_gen  = 1'b1;
                w_char = r_extra_char;
            end else if (r_left != '0) begin
                if (r_pend_valid) begin
                    w_gen = 1'b1;
                    if (w_pair < PAIR_LOWER) begin
                        w_char = 8'(w_pair) + LOWER_BASE;
                    end else if (w_pair < PAIR_UPPER) begin
                        w_char = 8'(w_pair) + UPPER_BASE;
                    end else begin
                        w_char = 8'(r_pend_digit) + ASCII_ZERO;
                    end
                end
            end else if (w_last && r_pend_valid) begin
                w_gen  = 1'b1;
                w_char = 8'(r_pend_digit) + ASCII_ZERO;
            end else begin
                w_flush = 1'b1;
            end
        end
        w_step = i_rec_valid && (!((w_gen || w_flush) && r_hold_valid) || w_out_free);
    end

    assign o_pop         = w_step && w_flush;
    assign o_valid       = r_out_valid;
    assign o_cipher_char = r_out_char;
    assign o_last_out    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded      <= 1'b0;
            r_left        <= '0;
            r_pend_valid  <= 1'b0;
            r_pend_digit  <= '0;
            r_extra_valid <= 1'b0;
            r_hold_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_last    <= 1'b0;
        end else begin
            // a held char leaves once we know whether another follows
            if (w_step && (w_gen || w_flush) && r_hold_valid) begin
                r_out_valid <= 1'b1;
                r_out_char  <= r_hold_char;
                r_out_last  <= w_flush && w_last;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_step) begin
                if (!r_loaded) begin
                    r_loaded <= 1'b1;
                    r_left   <= w_ndig;
                end else if (r_extra_valid) begin
                    r_extra_valid <= 1'b0;
                end else if (r_left != '0) begin
                    r_left <= w_idx;
                    if (!r_pend_valid) begin
                        r_pend_valid <= 1'b1;
                        r_pend_digit <= w_d;
                    end else begin
                        r_pend_valid <= 1'b0;
                        r_pend_digit <= '0;
                        if (w_pair >= PAIR_UPPER) begin
                            r_extra_valid <= 1'b1;
                            r_extra_char  <= 8'(w_d) + ASCII_ZERO;
                        end
                    end
                end else if (w_gen) begin
                    r_pend_valid <= 1'b0;
                    r_pend_digit <= '0;
                end else begin
                    r_loaded <= 1'b0;
                    if (w_last) begin
                        r_pend_valid <= 1'b0;
                        r_pend_digit <= '0;
                    end
                end
                if (w_gen) begin
                    r_hold_valid <= 1'b1;
                    r_hold_char  <= w_char;
                end else if (w_flush) begin
                    r_hold_valid <= 1'b0;
                end
            end
        end
    end

    a_extra_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extra_valid |-> !r_pend_valid)
        else $error("second char of a pair with a digit still open");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_loaded |-> (!r_extra_valid && !r_hold_valid))
        else $error("chars left over between requests");
    a_char_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_char >= 8'd97 && r_out_char <= 8'd122)
                      || (r_out_char >= 8'd65 && r_out_char <= 8'd90)
                      || (r_out_char >= 8'd48 && r_out_char <= 8'd57)))
        else $error("cipher char outside letters and digits");
endmodule

[hw/rtl/rsa_char_encrypt_letter_pack.sv]
// rsa byte encryptor with letter packing
// config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 modulus,
// 1 exponent); other indexes are ignored. write only while the block is idle.
// input channel: i_valid / o_stall carry one plaintext byte and its
// end-of-message flag; a request is taken when i_valid is high and o_stall low.
// output channel: o_valid / i_stall carry one cipher char per transfer;
// o_last_out marks the final char of a message.
// the front computes m^e mod n by square-and-multiply over all 32 exponent
// bits with a bit-serial modular multiplier, then splits the result into
// decimal digits; for e = 0 the multiplier is skipped.
// a two-entry queue lets the back pair digits and emit up to one char a
// cycle, unless the receiver stalls, while the front already works on the
// next byte. when the receiver stalls, chars wait in the output register
// and the queue fills; then the front holds o_stall high.
// reset loads modulus 3233, exponent 17 and drops any open digit.
module rsa_char_encrypt_letter_pack #(
    parameter int unsigned MOD_WIDTH  = 32,
    parameter int unsigned MAX_DIGITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [rcelp_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_plain_char,
    input  logic                        i_last_char,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_cipher_char,
    output logic                        o_last_out
);
    import rcelp_pkg::*;

    localparam int unsigned RW = MAX_DIGITS * DIGIT_W + NDIG_W + 1;

    logic [MOD_WIDTH-1:0] r_modulus;
    logic [EXP_W-1:0]     r_exponent;

    logic          w_push;
    logic [RW-1:0] w_rec_in;
    logic          w_full;
    logic          w_pop;
    logic          w_rec_valid;
    logic [RW-1:0] w_rec_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MOD_WIDTH'(3233);
            r_exponent <= EXP_W'(17);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODULUS) begin
                r_modulus <= i_cfg_data[MOD_WIDTH-1:0];
            end else if (i_cfg_idx == REG_EXPONENT) begin
                r_exponent <= i_cfg_data[EXP_W-1:0];
            end
        end
    end

    rcelp_front #(
        .MOD_WIDTH  (MOD_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_modulus    (r_modulus),
        .i_exponent   (r_exponent),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_plain_char (i_plain_char),
        .i_last_char  (i_last_char),
        .o_push       (w_push),
        .o_rec        (w_rec_in),
        .i_full       (w_full)
    );

    rcelp_fifo #(
        .WIDTH (RW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rec_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_rec_valid),
        .o_data  (w_rec_out)
    );

    rcelp_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec_valid   (w_rec_valid),
        .i_rec         (w_rec_out),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cipher_char (o_cipher_char),
        .o_last_out    (o_last_out)
    );
endmodule
